// File: design/pmst_pkg.sv
`default_nettype none
package pmst_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int V_BITS       = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_BITS    = 2 * V_BITS;
  localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
  localparam int TOTAL_BITS   = 20;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SUMMARY
  } state_t;

  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Requests from the controller to the adjacency store.
  typedef struct packed {
    logic                   wr_en;
    logic                   clr;
    logic                   rd_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [WEIGHT_BITS-1:0] wr_weight;
  } adj_req_t;

endpackage
`default_nettype wire

// File: design/pmst_adj_store.sv
`default_nettype none
module pmst_adj_store (
  input  wire                             clk,
  input  wire                             rst_n,
  input  pmst_pkg::adj_req_t              req,
  output logic                            rd_present,
  output logic [pmst_pkg::WEIGHT_BITS-1:0] rd_weight
);
  import pmst_pkg::*;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       vld_r;

  // Weight memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_weight;
    end
    if (req.rd_en) begin
      rd_weight <= mem[req.rd_addr];
    end
  end

  // Presence bits; a clear drops every entry at once.
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_present <= 1'b0;
    end else if (req.rd_en) begin
      rd_present <= vld_r[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: design/prim_minimum_spanning_tree_top.sv
`default_nettype none
// Prim spanning tree engine. A load word stores one undirected edge in a
// 256-entry adjacency memory (one entry per unordered pair); a clear word
// empties the memory. A run word grows the tree from vertex 0: each added
// vertex costs one sweep over the adjacency memory's single read port. A run
// ends early when the graph falls apart, and a finished result word holds it
// while out_stall is high. Each tree edge comes out as it is added, then one
// summary word with last set. Input is stalled while a run is in progress.
module prim_minimum_spanning_tree_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [pmst_pkg::CNT_BITS-1:0]     cfg_wdata,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [1:0]                        in_command,
  input  wire  [pmst_pkg::V_BITS-1:0]       in_vertex_a,
  input  wire  [pmst_pkg::V_BITS-1:0]       in_vertex_b,
  input  wire  [pmst_pkg::WEIGHT_BITS-1:0]  in_edge_weight_in,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_item_kind,
  output logic [pmst_pkg::V_BITS-1:0]       out_edge_low,
  output logic [pmst_pkg::V_BITS-1:0]       out_edge_high,
  output logic [pmst_pkg::WEIGHT_BITS-1:0]  out_edge_weight_out,
  output logic [pmst_pkg::TOTAL_BITS-1:0]   out_total_weight,
  output logic                              out_connected,
  output logic                              out_last
);
  import pmst_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_BITS-1:0]    vcount_r;
  logic [CNT_BITS-1:0]    n_r, n_eff;
  logic [V_BITS-1:0]      nm1_r;
  logic [V_BITS-1:0]      cur_r, rd_u_r, proc_u_r, pick_r;
  logic                   issuing_r, proc_vld_r, found_r;
  logic [WEIGHT_BITS-1:0] best_r;
  logic [CNT_BITS-1:0]    reached_r;
  logic [TOTAL_BITS-1:0]  sum_r;
  logic [MAX_VERTICES-1:0] visited_r, lp_r;
  logic [WEIGHT_BITS-1:0] cost_r [MAX_VERTICES];
  logic [V_BITS-1:0]      par_r  [MAX_VERTICES];

  adj_req_t               req;
  logic                   rd_present;
  logic [WEIGHT_BITS-1:0] rd_weight;

  logic in_acc, out_free, start_run, load_edge, load_sum, last_proc;
  logic upd, cand_lp;
  logic [WEIGHT_BITS-1:0] cand_cost;
  logic [TOTAL_BITS:0]    sum_wide;
  logic [TOTAL_BITS-1:0]  sum_new;
  logic [V_BITS-1:0]      par_pick;

  pmst_adj_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .rd_present (rd_present),
    .rd_weight  (rd_weight)
  );

  // Effective vertex count, clamped to 1..MAX_VERTICES.
  always_comb begin
    if (vcount_r == '0) begin
      n_eff = CNT_BITS'(1);
    end else if (vcount_r > CNT_BITS'(MAX_VERTICES)) begin
      n_eff = CNT_BITS'(MAX_VERTICES);
    end else begin
      n_eff = vcount_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign start_run = in_acc && (in_command == CMD_RUN);
  assign out_free  = !out_valid || !out_stall;
  assign last_proc = proc_vld_r && (proc_u_r == nm1_r);

  // Store requests: loads write the unordered pair, the sweep reads row cur.
  // Writes happen only in idle and reads only in a sweep, so they never meet.
  always_comb begin
    req = '0;
    req.wr_en     = in_acc && (in_command == CMD_LOAD) && (in_vertex_a != in_vertex_b);
    req.clr       = in_acc && (in_command == CMD_CLEAR);
    req.wr_weight = in_edge_weight_in;
    req.wr_addr   = (in_vertex_a < in_vertex_b) ? {in_vertex_a, in_vertex_b}
                                                : {in_vertex_b, in_vertex_a};
    req.rd_en     = (state_r == ST_SCAN) && issuing_r;
    req.rd_addr   = (cur_r < rd_u_r) ? {cur_r, rd_u_r} : {rd_u_r, cur_r};
  end

  // Relaxation of the vertex under process and its bid for next pick.
  always_comb begin
    upd = proc_vld_r && !visited_r[proc_u_r] && rd_present &&
          (!lp_r[proc_u_r] || (rd_weight < cost_r[proc_u_r]));
    cand_cost = upd ? rd_weight : cost_r[proc_u_r];
    cand_lp   = upd || lp_r[proc_u_r];
  end

  // Saturating total for an added edge.
  always_comb begin
    par_pick = par_r[pick_r];
    sum_wide = {1'b0, sum_r} + (TOTAL_BITS+1)'(best_r);
    sum_new  = sum_wide[TOTAL_BITS] ? TOTAL_MAX : sum_wide[TOTAL_BITS-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (start_run) state_nxt = ST_SCAN;
      ST_SCAN:    if (last_proc) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (!found_r) begin
          state_nxt = ST_SUMMARY;
        end else if (out_free) begin
          state_nxt = (reached_r + CNT_BITS'(1) == n_r) ? ST_SUMMARY : ST_SCAN;
        end
      end
      ST_SUMMARY: if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Output loads.
  always_comb begin
    load_edge = (state_r == ST_DECIDE) && found_r && out_free;
    load_sum  = (state_r == ST_SUMMARY) && out_free;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      vcount_r  <= CNT_BITS'(MAX_VERTICES);
      out_valid <= 1'b0;
      issuing_r <= 1'b0;
      proc_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) vcount_r <= cfg_wdata;
      if (load_edge || load_sum) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (start_run || (load_edge && state_nxt == ST_SCAN)) begin
        issuing_r <= 1'b1;
      end else if (req.rd_en && rd_u_r == nm1_r) begin
        issuing_r <= 1'b0;
      end
      proc_vld_r <= req.rd_en;
    end
  end

  // Run datapath.
  always_ff @(posedge clk) begin
    proc_u_r <= rd_u_r;
    if (req.rd_en) rd_u_r <= rd_u_r + V_BITS'(1);
    if (start_run) begin
      n_r       <= n_eff;
      nm1_r     <= V_BITS'(n_eff - CNT_BITS'(1));
      cur_r     <= '0;
      rd_u_r    <= '0;
      found_r   <= 1'b0;
      reached_r <= CNT_BITS'(1);
      sum_r     <= '0;
      visited_r <= MAX_VERTICES'(1);
      lp_r      <= '0;
    end
    if (proc_vld_r) begin
      if (upd) begin
        lp_r[proc_u_r]   <= 1'b1;
        cost_r[proc_u_r] <= rd_weight;
        par_r[proc_u_r]  <= cur_r;
      end
      if (!visited_r[proc_u_r] && cand_lp && (!found_r || cand_cost < best_r)) begin
        found_r <= 1'b1;
        best_r  <= cand_cost;
        pick_r  <= proc_u_r;
      end
    end
    if (load_edge) begin
      sum_r             <= sum_new;
      visited_r[pick_r] <= 1'b1;
      reached_r         <= reached_r + CNT_BITS'(1);
      cur_r             <= pick_r;
      rd_u_r            <= '0;
      found_r           <= 1'b0;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (load_edge) begin
      out_item_kind       <= KIND_EDGE;
      out_edge_low        <= (par_pick < pick_r) ? par_pick : pick_r;
      out_edge_high       <= (par_pick < pick_r) ? pick_r : par_pick;
      out_edge_weight_out <= best_r;
      out_total_weight    <= sum_new;
      out_connected       <= 1'b0;
      out_last            <= 1'b0;
    end else if (load_sum) begin
      out_item_kind       <= KIND_SUMMARY;
      out_edge_low        <= '0;
      out_edge_high       <= '0;
      out_edge_weight_out <= '0;
      out_total_weight    <= sum_r;
      out_connected       <= (reached_r == n_r);
      out_last            <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: verif/prim_minimum_spanning_tree_top_tb.sv
module prim_minimum_spanning_tree_top_tb;
  import pmst_pkg::*;

  typedef struct {
    logic                   kind;
    logic [V_BITS-1:0]      lo;
    logic [V_BITS-1:0]      hi;
    logic [WEIGHT_BITS-1:0] w;
    logic [TOTAL_BITS-1:0]  total;
    logic                   conn;
    logic                   last;
  } tree_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CNT_BITS-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_command;
  logic [V_BITS-1:0] in_vertex_a;
  logic [V_BITS-1:0] in_vertex_b;
  logic [WEIGHT_BITS-1:0] in_edge_weight_in;
  logic out_valid;
  logic out_stall;
  logic out_item_kind;
  logic [V_BITS-1:0] out_edge_low;
  logic [V_BITS-1:0] out_edge_high;
  logic [WEIGHT_BITS-1:0] out_edge_weight_out;
  logic [TOTAL_BITS-1:0] out_total_weight;
  logic out_connected;
  logic out_last;

  prim_minimum_spanning_tree_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .in_edge_weight_in(in_edge_weight_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_item_kind(out_item_kind),
    .out_edge_low(out_edge_low), .out_edge_high(out_edge_high),
    .out_edge_weight_out(out_edge_weight_out), .out_total_weight(out_total_weight),
    .out_connected(out_connected), .out_last(out_last)
  );

  // Mirror of the adjacency memory and the vertex count register.
  logic                   edge_there [MAX_VERTICES][MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] edge_cost [MAX_VERTICES][MAX_VERTICES];
  logic [CNT_BITS-1:0]    vertex_count;

  tree_word_t tree_words_due[$];
  int errors;
  int words_sent;
  bit idle_on;
  int out_hold;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void forget_edges();
    foreach (edge_there[i, j]) begin
      edge_there[i][j] = 1'b0;
      edge_cost[i][j] = '0;
    end
  endfunction

  // Grow the tree from vertex 0 exactly as the engine should, queueing each word.
  function automatic void grow_tree();
    int n;
    int reached;
    int pick;
    logic seen [MAX_VERTICES];
    logic has_link [MAX_VERTICES];
    logic [WEIGHT_BITS-1:0] link_cost [MAX_VERTICES];
    int link_from [MAX_VERTICES];
    logic [TOTAL_BITS-1:0] sum;
    tree_word_t tw;
    n = int'(vertex_count);
    if (n < 1) n = 1;
    if (n > MAX_VERTICES) n = MAX_VERTICES;
    foreach (seen[v]) begin
      seen[v] = 1'b0;
      has_link[v] = 1'b0;
      link_cost[v] = '0;
      link_from[v] = 0;
    end
    seen[0] = 1'b1;
    sum = '0;
    reached = 1;
    pick = 0;
    while (1) begin
      // Relax the links out of the vertex just added.
      for (int u = 0; u < n; u++) begin
        if (!seen[u] && edge_there[pick][u] &&
            (!has_link[u] || edge_cost[pick][u] < link_cost[u])) begin
          has_link[u] = 1'b1;
          link_cost[u] = edge_cost[pick][u];
          link_from[u] = pick;
        end
      end
      if (reached >= n) break;
      pick = -1;
      for (int v = 0; v < n; v++) begin
        if (!seen[v] && has_link[v] && (pick < 0 || link_cost[v] < link_cost[pick]))
          pick = v;
      end
      if (pick < 0) break;
      sum = sum + TOTAL_BITS'(link_cost[pick]);
      tw.kind = KIND_EDGE;
      tw.lo = V_BITS'((link_from[pick] < pick) ? link_from[pick] : pick);
      tw.hi = V_BITS'((link_from[pick] < pick) ? pick : link_from[pick]);
      tw.w = link_cost[pick];
      tw.total = sum;
      tw.conn = 1'b0;
      tw.last = 1'b0;
      tree_words_due.insert(tree_words_due.size(), tw);
      seen[pick] = 1'b1;
      reached++;
    end
    tw.kind = KIND_SUMMARY;
    tw.lo = '0;
    tw.hi = '0;
    tw.w = '0;
    tw.total = sum;
    tw.conn = (reached == n);
    tw.last = 1'b1;
    tree_words_due.insert(tree_words_due.size(), tw);
  endfunction

  // Offer one word, wait for it to be taken, then update the mirror.
  task automatic send_word(input cmd_t cmd, input int a, input int b, input int w);
    while (idle_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_vertex_a <= V_BITS'(a);
    in_vertex_b <= V_BITS'(b);
    in_edge_weight_in <= WEIGHT_BITS'(w);
    do @(posedge clk); while (!(in_valid && !in_stall));
    words_sent++;
    case (cmd)
      CMD_LOAD: begin
        if (a[V_BITS-1:0] != b[V_BITS-1:0]) begin
          edge_there[a[V_BITS-1:0]][b[V_BITS-1:0]] = 1'b1;
          edge_there[b[V_BITS-1:0]][a[V_BITS-1:0]] = 1'b1;
          edge_cost[a[V_BITS-1:0]][b[V_BITS-1:0]] = WEIGHT_BITS'(w);
          edge_cost[b[V_BITS-1:0]][a[V_BITS-1:0]] = WEIGHT_BITS'(w);
        end
      end
      CMD_RUN: grow_tree();
      CMD_CLEAR: forget_edges();
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tree_words_due.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the engine idle, after every result word is taken.
  task automatic set_vertex_count(input int value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_BITS'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    vertex_count = CNT_BITS'(value);
  endtask

  // Result side: check each taken word, then choose the next stall.
  initial begin
    tree_word_t tw;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (tree_words_due.size() == 0) begin
          report("unexpected word", out_item_kind, 0);
        end else begin
          tw = tree_words_due.pop_front();
          if (out_item_kind !== tw.kind) report("item_kind", out_item_kind, tw.kind);
          if (out_edge_low !== tw.lo) report("edge_low", out_edge_low, tw.lo);
          if (out_edge_high !== tw.hi) report("edge_high", out_edge_high, tw.hi);
          if (out_edge_weight_out !== tw.w) report("edge_weight", out_edge_weight_out, tw.w);
          if (out_total_weight !== tw.total) report("total", out_total_weight, tw.total);
          if (out_connected !== tw.conn) report("connected", out_connected, tw.conn);
          if (out_last !== tw.last) report("last", out_last, tw.last);
        end
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 17);
      end
    end
  end

  task automatic test_special_loads();
    send_word(CMD_LOAD, 0, 15, 16'hFFFF);
    send_word(CMD_LOAD, 3, 3, 5);
    send_word(CMD_LOAD, 0, 1, 0);
    send_word(CMD_LOAD, 1, 2, 9);
    send_word(CMD_LOAD, 2, 1, 4);
    send_word(CMD_LOAD, 0, 2, 4);
    send_word(CMD_LOAD, 15, 14, 1);
    send_word(CMD_NOP, 5, 6, 7);
    send_word(CMD_RUN, 0, 0, 0);
    set_vertex_count(3);
    send_word(CMD_RUN, 15, 15, 16'hFFFF);
    send_word(CMD_CLEAR, 0, 0, 0);
    send_word(CMD_RUN, 0, 0, 0);
    send_word(CMD_LOAD, 1, 0, 16'hFFFF);
    send_word(CMD_LOAD, 2, 0, 16'hFFFF);
    send_word(CMD_RUN, 0, 0, 0);
  endtask

  task automatic test_count_extremes();
    set_vertex_count(1);
    send_word(CMD_RUN, 0, 0, 0);
    set_vertex_count(0);
    send_word(CMD_RUN, 0, 0, 0);
    set_vertex_count(31);
    send_word(CMD_RUN, 0, 0, 0);
    set_vertex_count(16);
    send_word(CMD_RUN, 0, 0, 0);
  endtask

  // Random graphs: maybe clear, load edges, run; some noise words mixed in.
  task automatic test_random_graphs(input int budget);
    int n;
    int w;
    while (words_sent < budget) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      if (n != vertex_count) set_vertex_count(n);
      if ($urandom_range(4) != 0) send_word(CMD_CLEAR, $urandom, $urandom, $urandom);
      repeat ($urandom_range(1, 24)) begin
        w = $urandom_range(1) ? $urandom_range(0, 7) : $urandom_range(0, 65535);
        if ($urandom_range(19) == 0)
          send_word(CMD_NOP, $urandom_range(0, 15), $urandom_range(0, 15), w);
        else if ($urandom_range(9) == 0 || n < 2)
          send_word(CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, 15), w);
        else
          send_word(CMD_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1), w);
      end
      send_word(CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
    end
  endtask

  // Hold the result side long enough that the engine backs up into its input.
  task automatic test_backpressure();
    set_vertex_count(16);
    out_hold = 400;
    for (int v = 1; v < 16; v++) send_word(CMD_LOAD, v - 1, v, v * 100);
    send_word(CMD_RUN, 0, 0, 0);
    send_word(CMD_LOAD, 0, 8, 1);
    send_word(CMD_RUN, 0, 0, 0);
    send_word(CMD_RUN, 0, 0, 0);
    wait_drained();
    send_word(CMD_RUN, 0, 0, 0);
  endtask

  initial begin
    int waited;
    errors = 0;
    words_sent = 0;
    out_hold = 0;
    idle_on = 1'b1;
    vertex_count = 16;
    forget_edges();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_command = CMD_NOP;
    in_vertex_a = '0;
    in_vertex_b = '0;
    in_edge_weight_in = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_loads();
    test_count_extremes();
    test_random_graphs(150);
    // A stretch with no idling on either side.
    idle_on = 1'b0;
    test_random_graphs(230);
    idle_on = 1'b1;
    test_backpressure();
    test_random_graphs(310);

    in_valid <= 1'b0;
    waited = 0;
    while (tree_words_due.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && tree_words_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pmst_pkg.sv
design/pmst_adj_store.sv
design/prim_minimum_spanning_tree_top.sv
verif/prim_minimum_spanning_tree_top_tb.sv
